>>> src/hsft_pkg.sv
package hsft_pkg;

	// SHA-1 chaining value at the start of a hash, word 0 in element 0
	localparam logic [4:0][31:0] H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	// round constants, one per quarter
	localparam logic [31:0] K_Q0 = 32'h5A827999;
	localparam logic [31:0] K_Q1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_Q2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_Q3 = 32'hCA62C1D6;

	localparam logic [7:0] IPAD     = 8'h36;
	localparam logic [7:0] OPAD     = 8'h5c;
	localparam logic [7:0] PAD_MARK = 8'h80;

	// bit lengths in the closing block: pad block plus 14-byte frame or 20-byte digest
	localparam logic [31:0] MSG_LEN_BITS = 32'd624;
	localparam logic [31:0] DIG_LEN_BITS = 32'd672;

	localparam int unsigned ROUNDS = 80;
	localparam int unsigned RND_W  = 7;
	localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUNDS - 1);

	// configuration register indexes
	localparam logic [1:0] CFG_KEY_0_7   = 2'd0;
	localparam logic [1:0] CFG_KEY_8_15  = 2'd1;
	localparam logic [1:0] CFG_KEY_16_19 = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_ADD
	} state_t;

	// the four compressions of one tag, in order
	typedef enum logic [1:0] {
		BLK_IPAD,
		BLK_MSG,
		BLK_OPAD,
		BLK_DIG
	} blk_t;

	typedef struct packed {
		logic [31:0] f;
		logic [31:0] k;
	} fk_t;

	// round function and constant for round rnd
	function automatic fk_t round_fk(
		input logic [RND_W-1:0] rnd,
		input logic [31:0]      b,
		input logic [31:0]      c,
		input logic [31:0]      d
	);
		fk_t r;
		priority if (rnd < RND_W'(20)) begin
			r.f = (b & c) | (~b & d);
			r.k = K_Q0;
		end else if (rnd < RND_W'(40)) begin
			r.f = b ^ c ^ d;
			r.k = K_Q1;
		end else if (rnd < RND_W'(60)) begin
			r.f = (b & c) | (b & d) | (c & d);
			r.k = K_Q2;
		end else begin
			r.f = b ^ c ^ d;
			r.k = K_Q3;
		end
		return r;
	endfunction

	// sixteen message words of the selected block, word 0 in element 0
	function automatic logic [15:0][31:0] block_words(
		input blk_t             sel,
		input logic [63:0]      key_0_7,
		input logic [63:0]      key_8_15,
		input logic [31:0]      key_16_19,
		input logic [111:0]     msg,
		input logic [4:0][31:0] idig
	);
		logic [15:0][31:0] w;
		logic [4:0][31:0]  kw;
		logic [7:0]        pad;
		kw  = {key_16_19, key_8_15[31:0], key_8_15[63:32], key_0_7[31:0], key_0_7[63:32]};
		pad = (sel == BLK_IPAD) ? IPAD : OPAD;
		w   = '0;
		unique case (sel)
			BLK_IPAD, BLK_OPAD: begin
				for (int i = 0; i < 16; i++) begin
					w[i] = {4{pad}};
				end
				for (int i = 0; i < 5; i++) begin
					w[i] = kw[i] ^ {4{pad}};
				end
			end
			BLK_MSG: begin
				w[0]  = msg[111:80];
				w[1]  = msg[79:48];
				w[2]  = msg[47:16];
				w[3]  = {msg[15:0], PAD_MARK, 8'h00};
				w[15] = MSG_LEN_BITS;
			end
			BLK_DIG: begin
				for (int i = 0; i < 5; i++) begin
					w[i] = idig[i];
				end
				w[5]  = {PAD_MARK, 24'h000000};
				w[15] = DIG_LEN_BITS;
			end
			default: begin
				w = '0;
			end
		endcase
		return w;
	endfunction

endpackage

>>> src/hmac_sha1_frame_tag.sv
// HMAC-SHA1 tag of one 14-byte frame (identifier, data, nonce) under a
// 20-byte key.
// Config: write cfg_data to key register cfg_index while cfg_valid is high;
// cfg_ready is always high. Index 0 and 1 take 64 key bits, index 2 takes 32;
// index 3 is ignored. Write only while busy is low and no tag is pending.
// Command: a frame is taken at the edge where start is high and busy is low.
// busy stays high while the frame is hashed.
// Result: tag is shown for one cycle with tag_valid high, registered from the
// chaining add of the last compression; the receiver cannot hold it off. busy
// drops in that same cycle, so the next start may coincide with the tag beat.
// Sequence: the idle state takes the start, then come four compressions of one
// load, 80 rounds and one chaining add each on a single SHA-1 round unit doing
// one round a cycle; a new frame is taken only once the last tag is out.
// Reset: arst_n clears the sequencer and the key registers to zero.
module hmac_sha1_frame_tag (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [15:0]  frame_id,
	input  logic [63:0]  frame_data,
	input  logic [31:0]  nonce,
	output logic         tag_valid,
	output logic [15:0]  tag,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	hsft_pkg::state_t          state_q, state_d;
	hsft_pkg::blk_t            blk_q;
	logic [hsft_pkg::RND_W-1:0] rnd_q;
	logic                      load_en, round_en, add_en;

	logic [63:0]       key_0_7_q, key_8_15_q;
	logic [31:0]       key_16_19_q;
	logic [111:0]      msg_q;
	logic [4:0][31:0]  h_q, idig_q, sum;
	logic [31:0]       a_q, b_q, c_q, d_q, e_q;
	logic [31:0]       w_q [16];
	logic [15:0][31:0] blk_w;
	logic [31:0]       w_next, t_val;
	hsft_pkg::fk_t     fk;
	logic              tag_valid_q;
	logic [15:0]       tag_q;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != hsft_pkg::ST_IDLE);
	assign tag_valid = tag_valid_q;
	assign tag       = tag_q;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_0_7_q   <= '0;
			key_8_15_q  <= '0;
			key_16_19_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			priority if (cfg_index == hsft_pkg::CFG_KEY_0_7) begin
				key_0_7_q <= cfg_data;
			end else if (cfg_index == hsft_pkg::CFG_KEY_8_15) begin
				key_8_15_q <= cfg_data;
			end else if (cfg_index == hsft_pkg::CFG_KEY_16_19) begin
				key_16_19_q <= cfg_data[31:0];
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hsft_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath enables
	always_comb begin
		state_d  = state_q;
		load_en  = 1'b0;
		round_en = 1'b0;
		add_en   = 1'b0;
		unique case (state_q)
			hsft_pkg::ST_IDLE: begin
				if (start) begin
					state_d = hsft_pkg::ST_LOAD;
				end
			end
			hsft_pkg::ST_LOAD: begin
				load_en = 1'b1;
				state_d = hsft_pkg::ST_ROUND;
			end
			hsft_pkg::ST_ROUND: begin
				round_en = 1'b1;
				if (rnd_q == hsft_pkg::LAST_ROUND) begin
					state_d = hsft_pkg::ST_ADD;
				end
			end
			hsft_pkg::ST_ADD: begin
				add_en  = 1'b1;
				state_d = (blk_q == hsft_pkg::BLK_DIG) ? hsft_pkg::ST_IDLE
				                                      : hsft_pkg::ST_LOAD;
			end
			default: begin
				state_d = hsft_pkg::ST_IDLE;
			end
		endcase
	end

	// block and round counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q       <= hsft_pkg::BLK_IPAD;
			rnd_q       <= '0;
			tag_valid_q <= 1'b0;
		end else begin
			tag_valid_q <= add_en && (blk_q == hsft_pkg::BLK_DIG);
			if (state_q == hsft_pkg::ST_IDLE) begin
				blk_q <= hsft_pkg::BLK_IPAD;
			end else if (add_en) begin
				unique case (blk_q)
					hsft_pkg::BLK_IPAD: blk_q <= hsft_pkg::BLK_MSG;
					hsft_pkg::BLK_MSG:  blk_q <= hsft_pkg::BLK_OPAD;
					hsft_pkg::BLK_OPAD: blk_q <= hsft_pkg::BLK_DIG;
					hsft_pkg::BLK_DIG:  blk_q <= hsft_pkg::BLK_IPAD;
					default:            blk_q <= hsft_pkg::BLK_IPAD;
				endcase
			end
			if (load_en) begin
				rnd_q <= '0;
			end else if (round_en) begin
				rnd_q <= rnd_q + 1'b1;
			end
		end
	end

	// block contents, round logic and chaining sums
	assign blk_w  = hsft_pkg::block_words(blk_q, key_0_7_q, key_8_15_q, key_16_19_q,
	                                      msg_q, idig_q);
	assign w_next = {w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]} << 1
	              | {31'd0, w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};
	assign fk     = hsft_pkg::round_fk(rnd_q, b_q, c_q, d_q);
	assign t_val  = {a_q[26:0], a_q[31:27]} + fk.f + e_q + fk.k + w_q[0];
	assign sum    = {h_q[4] + e_q, h_q[3] + d_q, h_q[2] + c_q, h_q[1] + b_q, h_q[0] + a_q};

	// datapath
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			msg_q <= {frame_id, frame_data, nonce};
		end
		if (load_en) begin
			// pad blocks start a fresh hash, the others chain on h
			if (blk_q == hsft_pkg::BLK_IPAD || blk_q == hsft_pkg::BLK_OPAD) begin
				h_q <= hsft_pkg::H_INIT;
				a_q <= hsft_pkg::H_INIT[0];
				b_q <= hsft_pkg::H_INIT[1];
				c_q <= hsft_pkg::H_INIT[2];
				d_q <= hsft_pkg::H_INIT[3];
				e_q <= hsft_pkg::H_INIT[4];
			end else begin
				a_q <= h_q[0];
				b_q <= h_q[1];
				c_q <= h_q[2];
				d_q <= h_q[3];
				e_q <= h_q[4];
			end
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk_w[i];
			end
		end else if (round_en) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_next;
		end else if (add_en) begin
			h_q <= sum;
			if (blk_q == hsft_pkg::BLK_MSG) begin
				idig_q <= sum;
			end
			if (blk_q == hsft_pkg::BLK_DIG) begin
				tag_q <= {sum[4][7:0], sum[4][15:8]};
			end
		end
	end

endmodule

>>> tb/tb_hmac_sha1_frame_tag.sv
module tb_hmac_sha1_frame_tag;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [4:0][31:0]  chain_t;
	typedef logic [15:0][31:0] block_t;

	// SHA-1 start value, word 0 in element 0
	localparam chain_t INIT_CHAIN = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};
	localparam logic [31:0] RC0 = 32'h5A827999;
	localparam logic [31:0] RC1 = 32'h6ED9EBA1;
	localparam logic [31:0] RC2 = 32'h8F1BBCDC;
	localparam logic [31:0] RC3 = 32'hCA62C1D6;
	localparam logic [7:0]  INNER_PAD = 8'h36;
	localparam logic [7:0]  OUTER_PAD = 8'h5c;
	localparam logic [7:0]  END_MARK  = 8'h80;
	// pad block plus 14-byte frame, pad block plus 20-byte digest
	localparam logic [31:0] FRAME_BITS  = 32'd624;
	localparam logic [31:0] DIGEST_BITS = 32'd672;
	// index past the key registers; the block ignores writes to it
	localparam logic [1:0]  CFG_UNUSED  = 2'd3;
	localparam int          STALL_LIMIT = 2000;
	localparam int          RANDOM_FRAMES = 1700;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [15:0] frame_id = '0;
	logic [63:0] frame_data = '0;
	logic [31:0] nonce = '0;
	logic        tag_valid;
	logic [15:0] tag;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	// key as the block should hold it
	logic [63:0] key_0_7 = '0;
	logic [63:0] key_8_15 = '0;
	logic [31:0] key_16_19 = '0;

	logic [15:0] pending_tags[$];
	logic [15:0] want_tag;
	bit          no_idle = 1'b0;
	int          errors = 0;
	int          frames_sent = 0;
	int          tags_checked = 0;
	int          key_writes = 0;
	int          key_loads = 0;
	int          idle_cycles = 0;

	hmac_sha1_frame_tag DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.frame_id   (frame_id),
		.frame_data (frame_data),
		.nonce      (nonce),
		.tag_valid  (tag_valid),
		.tag        (tag),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// one SHA-1 compression of a 16-word block into the chaining value
	function automatic chain_t sha1_compress(input chain_t hv, input block_t blk);
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++) begin
			w[i] = blk[i];
		end
		for (int i = 16; i < 80; i++) begin
			w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		end
		a = hv[0];
		b = hv[1];
		c = hv[2];
		d = hv[3];
		e = hv[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = RC0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = RC1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = RC2;
			end else begin
				f = b ^ c ^ d;
				k = RC3;
			end
			t = rotl(a, 5) + f + e + k + w[r];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		hv[0] = hv[0] + a;
		hv[1] = hv[1] + b;
		hv[2] = hv[2] + c;
		hv[3] = hv[3] + d;
		hv[4] = hv[4] + e;
		return hv;
	endfunction

	// zero-padded key XORed with a pad byte
	function automatic block_t key_pad_block(input logic [7:0] pad);
		block_t blk;
		logic [4:0][31:0] kw;
		kw[0] = key_0_7[63:32];
		kw[1] = key_0_7[31:0];
		kw[2] = key_8_15[63:32];
		kw[3] = key_8_15[31:0];
		kw[4] = key_16_19;
		for (int i = 0; i < 16; i++) begin
			blk[i] = (i < 5 ? kw[i] : 32'h0) ^ {4{pad}};
		end
		return blk;
	endfunction

	// HMAC-SHA1 of one frame under the current key, cut down to the tag
	function automatic logic [15:0] compute_frame_tag(
		input logic [15:0] id,
		input logic [63:0] data,
		input logic [31:0] nc
	);
		logic [111:0] msg;
		block_t       blk;
		chain_t       inner, outer;
		msg = {id, data, nc};
		inner = sha1_compress(INIT_CHAIN, key_pad_block(INNER_PAD));
		blk = '0;
		blk[0] = msg[111:80];
		blk[1] = msg[79:48];
		blk[2] = msg[47:16];
		blk[3] = {msg[15:0], END_MARK, 8'h00};
		blk[15] = FRAME_BITS;
		inner = sha1_compress(inner, blk);
		outer = sha1_compress(INIT_CHAIN, key_pad_block(OUTER_PAD));
		blk = '0;
		for (int i = 0; i < 5; i++) begin
			blk[i] = inner[i];
		end
		blk[5] = {END_MARK, 24'h000000};
		blk[15] = DIGEST_BITS;
		outer = sha1_compress(outer, blk);
		return {outer[4][7:0], outer[4][15:8]};
	endfunction

	// tag check, oldest expectation first
	always @(posedge clk) begin
		if (arst_n && tag_valid) begin
			if (pending_tags.size() == 0) begin
				$display("%0t: tag beat with nothing expected: expected none, actual %h",
					$time, tag);
				errors++;
			end else begin
				want_tag = pending_tags.pop_front();
				tags_checked++;
				if (tag !== want_tag) begin
					$display("%0t: tag mismatch: expected %h, actual %h",
						$time, want_tag, tag);
					errors++;
				end
			end
		end
	end

	// watchdog: too long without any beat on any port
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || tag_valid || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// one config beat; valid stays high unless this is the last of a run
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val, input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			hsft_pkg::CFG_KEY_0_7:   key_0_7 = val;
			hsft_pkg::CFG_KEY_8_15:  key_8_15 = val;
			hsft_pkg::CFG_KEY_16_19: key_16_19 = val[31:0];
			default: ;
		endcase
		key_writes++;
		if (last) begin
			cfg_valid <= 1'b0;
		end
	endtask

	// full key load; upper half of the short register carries junk on purpose
	task automatic load_key(
		input logic [63:0] k0,
		input logic [63:0] k1,
		input logic [31:0] k2,
		input bit          stray
	);
		if (stray) begin
			write_reg(CFG_UNUSED, {$urandom, $urandom}, 1'b0);
		end
		write_reg(hsft_pkg::CFG_KEY_0_7, k0, 1'b0);
		write_reg(hsft_pkg::CFG_KEY_8_15, k1, 1'b0);
		write_reg(hsft_pkg::CFG_KEY_16_19, {32'($urandom), k2}, 1'b1);
		key_loads++;
	endtask

	// one frame beat; start is left high so a zero-gap follower needs no toggle
	task automatic send_frame(input logic [15:0] id, input logic [63:0] data,
		input logic [31:0] nc);
		int gap;
		bit after_idle;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		after_idle = no_idle ? 1'b0 : 1'($urandom_range(0, 1));
		if (after_idle || gap != 0) begin
			start <= 1'b0;
		end
		if (after_idle) begin
			do @(posedge clk); while (busy);
		end
		repeat (gap) @(posedge clk);
		start      <= 1'b1;
		frame_id   <= id;
		frame_data <= data;
		nonce      <= nc;
		do @(posedge clk); while (busy);
		pending_tags.push_back(compute_frame_tag(id, data, nc));
		frames_sent++;
	endtask

	task automatic stop_frames();
		start <= 1'b0;
	endtask

	// hold off until every expected tag is in
	task automatic drain_tags();
		stop_frames();
		while (pending_tags.size() != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_word64();
		case ($urandom_range(0, 7))
			0: return 64'h0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// reset key, field extremes and single-bit patterns
	task automatic test_reset_key();
		send_frame(16'h0000, 64'h0, 32'h0);
		send_frame(16'hffff, '1, 32'hffffffff);
		send_frame(16'h8000, 64'h8000_0000_0000_0000, 32'h8000_0000);
		send_frame(16'h0001, 64'h1, 32'h1);
		send_frame(16'ha5a5, 64'h5a5a_5a5a_5a5a_5a5a, 32'ha5a5a5a5);
		drain_tags();
	endtask

	// all-ones key, ignored index, junk above the short register, byte order
	task automatic test_key_writes();
		load_key('1, '1, 32'hffffffff, 1'b1);
		send_frame(16'h0000, 64'h0, 32'h0);
		send_frame(16'hffff, '1, 32'hffffffff);
		send_frame(16'h1234, 64'h0123_4567_89ab_cdef, 32'hdeadbeef);
		drain_tags();
		load_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f, 32'h1011_1213, 1'b1);
		send_frame(16'h0102, 64'h0304_0506_0708_090a, 32'h0b0c_0d0e);
		send_frame(16'hfedc, 64'hba98_7654_3210_0f1e, 32'h2d3c_4b5a);
		drain_tags();
		load_key(64'h0, 64'h0, 32'h0, 1'b0);
		send_frame(16'h7fff, 64'h7fff_ffff_ffff_ffff, 32'h7fffffff);
		drain_tags();
	endtask

	// random frames under a rotating key, with zero-gap stretches and drains
	task automatic test_random_frames(input int count);
		logic [63:0] k0, k1;
		logic [31:0] k2;
		for (int i = 0; i < count; i++) begin
			if (i % 150 == 0) begin
				drain_tags();
				case ($urandom_range(0, 3))
					0: begin
						k0 = '1;
						k1 = '1;
						k2 = '1;
					end
					1: begin
						k0 = '0;
						k1 = '0;
						k2 = '0;
					end
					2: begin
						k0 = {$urandom, $urandom};
						k1 = {$urandom, $urandom};
						k2 = $urandom;
					end
					default: begin
						k0 = {$urandom & $urandom, $urandom & $urandom};
						k1 = {$urandom & $urandom, $urandom & $urandom};
						k2 = $urandom & $urandom;
					end
				endcase
				load_key(k0, k1, k2, 1'($urandom_range(0, 1)));
			end else if ($urandom_range(0, 63) == 0) begin
				drain_tags();
			end
			no_idle = ((i / 25) % 4 == 1);
			send_frame(16'(pick_word64()), pick_word64(), 32'(pick_word64()));
		end
		no_idle = 1'b0;
		drain_tags();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_key();
		test_key_writes();
		test_random_frames(RANDOM_FRAMES);
		drain_tags();
		repeat (20) @(posedge clk);
		$display("Covered %0d frames and %0d tags under %0d key loads (%0d config beats),",
			frames_sent, tags_checked, key_loads, key_writes);
		$display("including field extremes, ignored index writes and back-to-back starts.");
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
